/* rtl/core/sts_pkg.sv */
// Shared types and constants for the sorted table binary search block.
// No dependencies; sts_if, sts_seq and sorted_table_binary_search use this package.
package sts_pkg;

    // Field widths fixed by the item format
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int DATA_W  = 32;

    // Default table size
    localparam int DEPTH_DEF = 1024;

    // Item action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Result offered by the search sequencer to the output stage
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [INDEX_W-1:0] index;
    } t_res;

endpackage

/* rtl/core/sts_if.sv */
// Valid/ready channel interfaces for request items and search results.
// Depends on sts_pkg for the field widths.
interface sts_req_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [sts_pkg::INDEX_W-1:0]         entry_index;
    logic signed [sts_pkg::DATA_W-1:0]   entry_value;
    logic signed [sts_pkg::DATA_W-1:0]   search_key;

    modport source (output valid, action, entry_index, entry_value, search_key,
                    input ready);
    modport sink   (input valid, action, entry_index, entry_value, search_key,
                    output ready);
endinterface

interface sts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [sts_pkg::INDEX_W-1:0] match_index;

    modport source (output valid, found, match_index, input ready);
    modport sink   (input valid, found, match_index, output ready);
endinterface

/* rtl/core/sorted_table_binary_search.sv */
// Sorted table binary search: request channel i_req, result channel o_rsp,
// one configuration register (entry count) written through i_cfg_we/i_cfg_wdata.
// A write item (action 0) stores entry_value at entry_index and
// gives no result; indexes at or beyond the table depth are dropped.
// A search item (action 1) probes the table with one RAM read per cycle, the
// next probe address being chosen from the compare of the previous read.
// A search is accepted and then makes at most floor(log2(count)) + 1 probes.
// The table RAM has a single read port, so the probes are issued one by one.
// The result enters the output register from the compare of the last probe
// when the output register is free, else the sequencer holds it in S_DONE.
// A count of zero gives not found through the S_DONE state, with no table read.
// The output register lets the next item be taken while a result waits;
// if the receiver stalls and a second result is ready, the sequencer holds
// it and drops i_req.ready until the output drains.
// Reset (synchronous, active low) clears the entry count and all handshake
// state; table contents are undefined until written.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sts_pkg::COUNT_W-1:0] i_cfg_wdata,
    sts_req_if.sink                     i_req,
    sts_rsp_if.source                   o_rsp
);
    import sts_pkg::*;

    logic [COUNT_W-1:0] r_entry_count;
    logic               r_out_valid;
    logic               r_out_found;
    logic [INDEX_W-1:0] r_out_index;
    t_res               w_res;
    logic               w_take;

    // Entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // Search sequencer with table RAM
    sts_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_count (r_entry_count),
        .i_req         (i_req),
        .o_res         (w_res),
        .i_take        (w_take)
    );

    // Output register: load when empty or being drained this cycle
    assign w_take = w_res.valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out_found <= w_res.found;
            r_out_index <= w_res.index;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.match_index = r_out_index;

    // A not-found result always carries index zero
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> r_out_index == '0)
        else $error("not-found result with non-zero index");

    // A search occupies the sequencer: no transfer in the following cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && i_req.action == ACT_SEARCH |=> !i_req.ready)
        else $error("request taken while a search is in progress");

    // A finished result that is not taken stays offered
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid && !w_take |=> w_res.valid)
        else $error("search result dropped before reaching the output");

endmodule

/* rtl/core/sts_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sts_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sts_seq.sv */
// Request handling and binary search sequencer around the table RAM.
// Depends on sts_pkg, sts_if (request channel) and sts_ram.
module sts_seq #(
    parameter int TABLE_DEPTH = sts_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sts_pkg::COUNT_W-1:0]  i_entry_count,
    sts_req_if.sink                      i_req,
    output sts_pkg::t_res                o_res,
    input  logic                         i_take
);
    import sts_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_lo, n_lo;
    logic [CNT_W-1:0]    r_hi, n_hi;
    logic [CNT_W-1:0]    r_mid, n_mid;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic                r_found, n_found;
    logic [INDEX_W-1:0]  r_index, n_index;

    logic                w_accept;
    logic                w_we;
    logic [31:0]         w_widx;
    logic [ADDR_W-1:0]   w_waddr;
    logic                w_re;
    logic [CNT_W-1:0]    w_raddr_full;
    logic [DATA_W-1:0]   w_rdata;
    logic [CNT_W-1:0]    w_cnt_sat;
    logic [CNT_W-1:0]    w_mid0;
    logic [CNT_W-1:0]    w_lo_up;
    logic [CNT_W-1:0]    w_mid_up;
    logic [CNT_W-1:0]    w_mid_dn;
    logic                w_up_ok;
    logic                w_dn_ok;
    logic                w_eq;
    logic                w_less;
    logic [31:0]         w_mid32;
    logic [INDEX_W-1:0]  w_mid_index;

    // floor((left+right)/2) on the half-open window [lo, hi), with lo < hi
    function automatic logic [CNT_W-1:0] f_mid(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] hi);
        logic [CNT_W:0] s;
        s = {1'b0, lo} + {1'b0, hi} - (CNT_W+1)'(1);
        return s[CNT_W:1];
    endfunction

    // Table storage
    sts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_req.entry_value),
        .i_re    (w_re),
        .i_raddr (w_raddr_full[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Request side: one item at a time, writes go straight to the RAM
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_widx      = 32'(i_req.entry_index);
    assign w_waddr     = w_widx[ADDR_W-1:0];
    assign w_we        = w_accept && (i_req.action == ACT_WRITE) &&
                         (w_widx < 32'(TABLE_DEPTH));

    // Clamp the count to the table size
    always_comb begin
        if (32'(i_entry_count) > 32'(TABLE_DEPTH)) begin
            w_cnt_sat = CNT_W'(TABLE_DEPTH);
        end else begin
            w_cnt_sat = CNT_W'(i_entry_count);
        end
    end

    assign w_mid0 = f_mid('0, w_cnt_sat);

    // Both possible next probes, worked out from registers while the read is in flight
    assign w_lo_up  = r_mid + CNT_W'(1);
    assign w_mid_up = f_mid(w_lo_up, r_hi);
    assign w_mid_dn = f_mid(r_lo, r_mid);
    assign w_up_ok  = (w_lo_up < r_hi);
    assign w_dn_ok  = (r_lo < r_mid);

    // Compare the probed entry with the key
    assign w_eq   = ($signed(w_rdata) == r_key);
    assign w_less = ($signed(w_rdata) < r_key);

    assign w_mid32     = 32'(r_mid);
    assign w_mid_index = w_mid32[INDEX_W-1:0];

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_key        = r_key;
        n_found      = r_found;
        n_index      = r_index;
        w_re         = 1'b0;
        w_raddr_full = w_mid0;
        o_res        = '{valid: r_state == S_DONE, found: r_found, index: r_index};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req.action == ACT_SEARCH)) begin
                    n_key = i_req.search_key;
                    if (w_cnt_sat == '0) begin
                        // Empty table: report not found
                        n_found = 1'b0;
                        n_index = '0;
                        n_state = S_DONE;
                    end else begin
                        n_lo         = '0;
                        n_hi         = w_cnt_sat;
                        n_mid        = w_mid0;
                        w_re         = 1'b1;
                        w_raddr_full = w_mid0;
                        n_state      = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                priority if (w_eq) begin
                    o_res = '{valid: 1'b1, found: 1'b1, index: w_mid_index};
                end else if (w_less) begin
                    n_lo = w_lo_up;
                    if (w_up_ok) begin
                        n_mid        = w_mid_up;
                        w_re         = 1'b1;
                        w_raddr_full = w_mid_up;
                    end else begin
                        o_res = '{valid: 1'b1, found: 1'b0, index: '0};
                    end
                end else begin
                    n_hi = r_mid;
                    if (w_dn_ok) begin
                        n_mid        = w_mid_dn;
                        w_re         = 1'b1;
                        w_raddr_full = w_mid_dn;
                    end else begin
                        o_res = '{valid: 1'b1, found: 1'b0, index: '0};
                    end
                end
                // Finished: hand over now, or hold the result until the output frees up
                if (o_res.valid) begin
                    n_found = o_res.found;
                    n_index = o_res.index;
                    n_state = i_take ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and search registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_found <= n_found;
        r_index <= n_index;
    end

endmodule
